// ===== design/low_degree_polynomial_roots_unit_macros.svh =====
// ----------------------------------------------------------------------------
// low_degree_polynomial_roots_unit_macros
// assertion macros shared by the root solver modules
// ----------------------------------------------------------------------------
`ifndef LOW_DEGREE_POLYNOMIAL_ROOTS_UNIT_MACROS_SVH
`define LOW_DEGREE_POLYNOMIAL_ROOTS_UNIT_MACROS_SVH

// same-cycle implication
`define LPR_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lpr assertion failed");

// next-cycle implication
`define LPR_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lpr assertion failed");

`endif

// ===== design/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// shared types and codes of the low degree polynomial root solver
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int OUT_BITS = 32;
  localparam int IN_BITS  = 32;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOROOT   = 3'd1,
    ST_ZEROLEAD = 3'd2,
    ST_UNSUP    = 3'd3,
    ST_SAT      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_FLAG,
    K_LIN,
    K_QUAD
  } kind_t;

  // classification passed from front to back
  typedef struct packed {
    kind_t   kind;
    status_t status;
  } class_t;

  localparam int CLASS_BITS = $bits(class_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DISC,
    S_SQRT,
    S_ROOT,
    S_DIV,
    S_OUT0,
    S_OUT1
  } state_t;

  typedef enum logic [1:0] {
    M_ONE,
    M_REAL2,
    M_CPLX
  } mode_t;

endpackage

// ===== design/lpr_front.sv =====
// ----------------------------------------------------------------------------
// lpr_front
// decodes coefficients to sign and magnitude and classifies the polynomial
// ----------------------------------------------------------------------------
module lpr_front #(
  parameter int CW = 32
) (
  input  logic [1:0]                   degree,
  input  logic [lpr_pkg::IN_BITS-1:0]  coef_a0,
  input  logic [lpr_pkg::IN_BITS-1:0]  coef_a1,
  input  logic [lpr_pkg::IN_BITS-1:0]  coef_a2,
  output lpr_pkg::class_t              cls,
  output logic                         a0_neg,
  output logic [CW-1:0]                a0_mag,
  output logic                         a1_neg,
  output logic [CW-1:0]                a1_mag,
  output logic                         a2_neg,
  output logic [CW-1:0]                a2_mag
);
  import lpr_pkg::*;

  logic [CW-1:0] v0, v1, v2;

  // two's complement to sign and magnitude
  always_comb begin
    v0 = coef_a0[CW-1:0];
    v1 = coef_a1[CW-1:0];
    v2 = coef_a2[CW-1:0];
    a0_neg = v0[CW-1];
    a1_neg = v1[CW-1];
    a2_neg = v2[CW-1];
    a0_mag = a0_neg ? (~v0 + 1'b1) : v0;
    a1_mag = a1_neg ? (~v1 + 1'b1) : v1;
    a2_mag = a2_neg ? (~v2 + 1'b1) : v2;
  end

  // degree and zero checks
  always_comb begin
    cls.kind   = K_FLAG;
    cls.status = ST_OK;
    unique case (degree)
      2'd0: begin
        cls.kind   = K_FLAG;
        cls.status = (a0_mag != '0) ? ST_NOROOT : ST_OK;
      end
      2'd1: begin
        if (a1_mag == '0) begin
          cls.status = ST_ZEROLEAD;
        end else begin
          cls.kind = K_LIN;
        end
      end
      2'd2: begin
        if (a2_mag == '0) begin
          cls.status = ST_ZEROLEAD;
        end else begin
          cls.kind = K_QUAD;
        end
      end
      default: begin
        cls.status = ST_UNSUP;
      end
    endcase
  end

endmodule

// ===== design/lpr_fifo.sv =====
// ----------------------------------------------------------------------------
// lpr_fifo
// two-entry queue between the classifier and the solver engine
// ----------------------------------------------------------------------------
module lpr_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid
);
  `include "low_degree_polynomial_roots_unit_macros.svh"

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `LPR_ASSERT_IMP(a_fifo_bound, clk, rst, 1'b1, count != 2'd3)

endmodule

// ===== design/lpr_back.sv =====
// ----------------------------------------------------------------------------
// lpr_back
// solver engine: products, discriminant, square root, divisions, results
// ----------------------------------------------------------------------------
module lpr_back #(
  parameter int CW        = 32,
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  output logic                         job_pop,
  input  lpr_pkg::class_t              cls,
  input  logic                         a0_neg,
  input  logic [CW-1:0]                a0_mag,
  input  logic                         a1_neg,
  input  logic [CW-1:0]                a1_mag,
  input  logic                         a2_neg,
  input  logic [CW-1:0]                a2_mag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lpr_pkg::OUT_BITS-1:0] root_real,
  output logic [lpr_pkg::OUT_BITS-1:0] root_imag,
  output logic [2:0]                   status,
  output logic                         last
);
  import lpr_pkg::*;
  `include "low_degree_polynomial_roots_unit_macros.svh"

  localparam int NW    = CW + 2;             // numerator magnitude
  localparam int DNW   = CW + 1;             // divisor width
  localparam int XW    = NW + FRAC_BITS;     // dividend / quotient
  localparam int SQW   = CW + 1;             // square root width
  localparam int RADW  = 2 * SQW;            // radicand width
  localparam int SRW   = CW + 3;             // root remainder
  localparam int QMAX  = (XW > WORD_BITS) ? XW : WORD_BITS;
  localparam int CMPW  = ((QMAX > OUT_BITS) ? QMAX : OUT_BITS) + 1;
  localparam int CNTW  = $clog2(XW + 1);
  localparam logic [CMPW-1:0] LIM_NEG = {{(CMPW-1){1'b0}}, 1'b1} << (WORD_BITS - 1);
  localparam logic [CMPW-1:0] LIM_POS = LIM_NEG - 1'b1;

  state_t state, state_next;

  // job registers
  status_t          st_r;
  mode_t            mode;
  logic             r_a0n, r_a1n, r_a2n;
  logic [CW-1:0]    r_a0m, r_a1m, r_a2m;
  logic [2*CW-1:0]  b2, prod;
  logic             dpos;
  // square root
  logic [RADW-1:0]  rad;
  logic [SQW-1:0]   root;
  logic [SRW-1:0]   srem;
  // divider
  logic [XW-1:0]    dx;
  logic [DNW-1:0]   dden;
  logic [DNW-1:0]   drem;
  logic [CNTW-1:0]  cnt;
  logic             tgt;
  logic             two;
  logic [NW-1:0]    numb;
  // quotients
  logic [XW-1:0]    qa, qb;
  logic             nega, negb;

  // strobes
  logic out_load;
  logic last_step;

  // combinational helpers
  logic [2*CW+1:0]  four, b2e;
  logic [SRW+1:0]   sq_t, sq_trial;
  logic             sq_ge;
  logic [DNW:0]     dv_t;
  logic             dv_ge;
  logic [XW-1:0]    dx_n;
  logic [DNW-1:0]   drem_n;
  logic             nbneg;
  logic signed [CW+2:0] nb, se, n1, n2;
  logic [NW-1:0]    m1, m2;
  logic [DNW-1:0]   den2;

  function automatic logic [OUT_BITS:0] clampv(input logic neg, input logic [XW-1:0] mag);
    logic [CMPW-1:0]     m;
    logic [CMPW-1:0]     lim;
    logic [OUT_BITS-1:0] v;
    logic                sat;
    m   = CMPW'(mag);
    lim = neg ? LIM_NEG : LIM_POS;
    sat = (m > lim);
    if (sat) begin
      m = lim;
    end
    v = m[OUT_BITS-1:0];
    if (neg) begin
      v = ~v + 1'b1;
    end
    return {sat, v};
  endfunction

  // datapath helpers
  always_comb begin
    four     = {prod, 2'b00};
    b2e      = {2'b00, b2};
    sq_t     = {srem, rad[RADW-1 -: 2]};
    sq_trial = (SRW+2)'({root, 2'b01});
    sq_ge    = (sq_t >= sq_trial);
    dv_t     = {drem, dx[XW-1]};
    dv_ge    = (dv_t >= {1'b0, dden});
    drem_n   = dv_ge ? DNW'(dv_t - {1'b0, dden}) : dv_t[DNW-1:0];
    dx_n     = {dx[XW-2:0], dv_ge};
    nbneg    = !r_a1n && (r_a1m != '0);
    nb       = nbneg ? -$signed({3'b000, r_a1m}) : $signed({3'b000, r_a1m});
    se       = $signed({2'b00, root});
    n1       = nb + se;
    n2       = nb - se;
    m1       = n1[CW+2] ? NW'(-n1) : NW'(n1);
    m2       = n2[CW+2] ? NW'(-n2) : NW'(n2);
    den2     = {r_a2m, 1'b0};
    last_step = (cnt == CNTW'(1));
  end

  // result selection and clamping
  logic             re_neg, im_neg;
  logic [XW-1:0]    re_mag, im_mag;
  logic [OUT_BITS:0] re_c, im_c;

  always_comb begin
    re_neg = nega;
    re_mag = qa;
    im_neg = 1'b0;
    im_mag = '0;
    if (state == S_OUT0) begin
      if (mode == M_CPLX) begin
        im_neg = negb;
        im_mag = qb;
      end
    end else begin
      if (mode == M_CPLX) begin
        im_neg = !negb;
        im_mag = qb;
      end else begin
        re_neg = negb;
        re_mag = qb;
      end
    end
    re_c = clampv(re_neg, re_mag);
    im_c = clampv(im_neg, im_mag);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          unique case (cls.kind)
            K_LIN:   state_next = S_DIV;
            K_QUAD:  state_next = S_MUL1;
            default: state_next = S_OUT0;
          endcase
        end
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_DISC;
      S_DISC: begin
        if (!(r_a2n != r_a0n && prod != '0) && b2e == four) begin
          state_next = S_DIV;
        end else begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (last_step) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: state_next = S_DIV;
      S_DIV: begin
        if (last_step && !(tgt == 1'b0 && two)) begin
          state_next = S_OUT0;
        end
      end
      S_OUT0: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = (mode == M_ONE) ? S_IDLE : S_OUT1;
        end
      end
      S_OUT1: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        r_a0n <= a0_neg;
        r_a1n <= a1_neg;
        r_a2n <= a2_neg;
        r_a0m <= a0_mag;
        r_a1m <= a1_mag;
        r_a2m <= a2_mag;
        st_r  <= (cls.kind == K_FLAG) ? cls.status : ST_OK;
        mode  <= M_ONE;
        qa    <= '0;
        tgt   <= 1'b0;
        two   <= 1'b0;
        // linear root starts its division at once
        dx    <= {NW'(a0_mag), {FRAC_BITS{1'b0}}};
        dden  <= DNW'(a1_mag);
        drem  <= '0;
        cnt   <= CNTW'(XW);
        nega  <= (cls.kind == K_LIN) ? (a0_neg == a1_neg) : 1'b0;
      end
      S_MUL1: begin
        b2 <= r_a1m * r_a1m;
      end
      S_MUL2: begin
        prod <= r_a2m * r_a0m;
      end
      S_DISC: begin
        // discriminant sign and magnitude into the root radicand
        if (r_a2n != r_a0n && prod != '0) begin
          rad  <= b2e + four;
          dpos <= 1'b1;
        end else if (b2e > four) begin
          rad  <= b2e - four;
          dpos <= 1'b1;
        end else begin
          rad  <= four - b2e;
          dpos <= 1'b0;
        end
        root <= '0;
        srem <= '0;
        // double root goes straight to a full division
        if (!(r_a2n != r_a0n && prod != '0) && b2e == four) begin
          cnt <= CNTW'(XW);
        end else begin
          cnt <= CNTW'(SQW);
        end
        // double root division
        dx   <= {NW'(r_a1m), {FRAC_BITS{1'b0}}};
        dden <= den2;
        drem <= '0;
        nega <= nbneg != r_a2n;
        mode <= M_ONE;
      end
      S_SQRT: begin
        // one root bit per cycle
        rad  <= {rad[RADW-3:0], 2'b00};
        srem <= sq_ge ? SRW'(sq_t - sq_trial) : SRW'(sq_t);
        root <= {root[SQW-2:0], sq_ge};
        cnt  <= cnt - 1'b1;
      end
      S_ROOT: begin
        drem <= '0;
        cnt  <= CNTW'(XW);
        dden <= den2;
        two  <= 1'b1;
        tgt  <= 1'b0;
        if (dpos) begin
          mode <= M_REAL2;
          nega <= n1[CW+2] != r_a2n;
          negb <= n2[CW+2] != r_a2n;
          dx   <= {m1, {FRAC_BITS{1'b0}}};
          numb <= m2;
        end else begin
          mode <= M_CPLX;
          nega <= nbneg != r_a2n;
          negb <= r_a2n;
          dx   <= {NW'(r_a1m), {FRAC_BITS{1'b0}}};
          numb <= NW'(root);
        end
      end
      S_DIV: begin
        // one quotient bit per cycle, second numerator loaded after the first
        if (last_step && tgt == 1'b0 && two) begin
          qa   <= dx_n;
          tgt  <= 1'b1;
          dx   <= {numb, {FRAC_BITS{1'b0}}};
          drem <= '0;
          cnt  <= CNTW'(XW);
        end else begin
          dx   <= dx_n;
          drem <= drem_n;
          cnt  <= cnt - 1'b1;
          if (last_step) begin
            if (tgt == 1'b0) begin
              qa <= dx_n;
            end else begin
              qb <= dx_n;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      root_real <= re_c[OUT_BITS-1:0];
      root_imag <= im_c[OUT_BITS-1:0];
      status    <= (re_c[OUT_BITS] || im_c[OUT_BITS]) ? ST_SAT : st_r;
      last      <= (state == S_OUT1) || (mode == M_ONE);
    end
  end

  `LPR_ASSERT_IMP(a_flag_zero, clk, rst, out_valid && (status == ST_NOROOT || status == ST_ZEROLEAD || status == ST_UNSUP), root_real == '0 && root_imag == '0 && last)
  `LPR_ASSERT_IMP(a_div_nonzero, clk, rst, state == S_DIV, dden != '0)
  `LPR_ASSERT_NXT(a_second_root, clk, rst, out_load && state == S_OUT0 && mode != M_ONE, state == S_OUT1)

endmodule

// ===== design/low_degree_polynomial_roots_unit.sv =====
// flow: flag items go straight to the result, linear items to the divider;
// quadratics pass products, discriminant, square root but for a double root, divider
// throughput: set by the shared bit-serial divider and square root unit, one item
// in the back end at a time; a two-entry queue lets the input side keep accepting
// reset: synchronous active-high rst empties the queue and clears the output valid
// ----------------------------------------------------------------------------
// low_degree_polynomial_roots_unit
// roots of polynomials up to degree two in signed fixed point
// ----------------------------------------------------------------------------
module low_degree_polynomial_roots_unit #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          degree,
  input  logic signed [lpr_pkg::IN_BITS-1:0]  coef_a0,
  input  logic signed [lpr_pkg::IN_BITS-1:0]  coef_a1,
  input  logic signed [lpr_pkg::IN_BITS-1:0]  coef_a2,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lpr_pkg::OUT_BITS-1:0] root_real,
  output logic signed [lpr_pkg::OUT_BITS-1:0] root_imag,
  output logic [2:0]                          status,
  output logic                                last
);
  import lpr_pkg::*;

  localparam int CW = (WORD_BITS < IN_BITS) ? WORD_BITS : IN_BITS;
  localparam int EW = CLASS_BITS + 3 * (CW + 1);

  class_t        f_cls, b_cls;
  logic          f_a0n, f_a1n, f_a2n, b_a0n, b_a1n, b_a2n;
  logic [CW-1:0] f_a0m, f_a1m, f_a2m, b_a0m, b_a1m, b_a2m;
  logic [EW-1:0] q_din, q_dout;
  logic          q_full, q_valid, q_pop, push;

  lpr_front #(.CW(CW)) u_front (
    .degree (degree),
    .coef_a0(coef_a0),
    .coef_a1(coef_a1),
    .coef_a2(coef_a2),
    .cls    (f_cls),
    .a0_neg (f_a0n),
    .a0_mag (f_a0m),
    .a1_neg (f_a1n),
    .a1_mag (f_a1m),
    .a2_neg (f_a2n),
    .a2_mag (f_a2m)
  );

  // queue between classifier and engine
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign q_din    = {f_cls, f_a0n, f_a0m, f_a1n, f_a1m, f_a2n, f_a2m};
  assign {b_cls, b_a0n, b_a0m, b_a1n, b_a1m, b_a2n, b_a2m} = q_dout;

  lpr_fifo #(.W(EW)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .valid(q_valid)
  );

  lpr_back #(
    .CW       (CW),
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_valid),
    .job_pop  (q_pop),
    .cls      (b_cls),
    .a0_neg   (b_a0n),
    .a0_mag   (b_a0m),
    .a1_neg   (b_a1n),
    .a1_mag   (b_a1m),
    .a2_neg   (b_a2n),
    .a2_mag   (b_a2m),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .root_real(root_real),
    .root_imag(root_imag),
    .status   (status),
    .last     (last)
  );

endmodule

// ===== tb/sv/low_degree_polynomial_roots_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// low_degree_polynomial_roots_unit_tb
// self-checking bench for the root solver: a directed table of polynomials
// then random ones; each item's roots come from a fixed point model of its
// own or a typed status, and are compared field by field as they come back
// ----------------------------------------------------------------------------
module low_degree_polynomial_roots_unit_tb;
  import lpr_pkg::*;

  localparam int FRAC = 16;
  localparam int N_RANDOM = 1230;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_t            st;
    logic               lst;
  } root_t;

  typedef struct {
    logic [1:0]         deg;
    logic signed [31:0] a0, a1, a2;
    bit                 typed;
    status_t            st;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] degree = '0;
  logic signed [31:0] coef_a0 = '0, coef_a1 = '0, coef_a2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] root_real, root_imag;
  logic [2:0] status;
  logic last;

  root_t     roots_due[$];
  stim_row_t dir_rows[$];
  int err_count = 0;
  int n_items = 0;
  int n_results = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  low_degree_polynomial_roots_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .degree(degree), .coef_a0(coef_a0), .coef_a1(coef_a1), .coef_a2(coef_a2),
    .out_valid(out_valid), .out_ready(out_ready),
    .root_real(root_real), .root_imag(root_imag), .status(status), .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------- root prediction ----------------

  // clamp a sign/magnitude part to 32 bits; bit 32 flags saturation
  function automatic logic [32:0] clamp_part(bit neg, logic [127:0] mag);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    m = mag;
    if (m > lim) begin
      return {1'b1, neg ? 32'h8000_0000 : 32'h7fff_ffff};
    end
    return {1'b0, neg ? 32'(-m) : 32'(m)};
  endfunction

  function automatic logic [127:0] fx_quot(logic [127:0] num, logic [127:0] den);
    return (num << FRAC) / den;
  endfunction

  function automatic logic [127:0] floor_sqrt(logic [127:0] d);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= d) r = c;
    end
    return r;
  endfunction

  function automatic void push_root(bit nr, logic [127:0] mr, bit ni, logic [127:0] mi,
                                    status_t st, bit lst);
    logic [32:0] pr;
    logic [32:0] pi;
    root_t r;
    pr = clamp_part(nr, mr);
    pi = clamp_part(ni, mi);
    r.re = pr[31:0];
    r.im = pi[31:0];
    r.st = (pr[32] || pi[32]) ? ST_SAT : st;
    r.lst = lst;
    roots_due.push_back(r);
  endfunction

  // expected roots of one accepted polynomial
  function automatic void predict_roots(logic [1:0] deg, logic signed [31:0] c0,
                                        logic signed [31:0] c1, logic signed [31:0] c2);
    logic signed [127:0] a0, a1, a2, disc, nb, n1, n2;
    logic [127:0] m0, m1, m2, den, s;
    bit ng0, ng1, ng2, nbneg;
    a0 = c0; a1 = c1; a2 = c2;
    ng0 = a0 < 0; ng1 = a1 < 0; ng2 = a2 < 0;
    m0 = ng0 ? -a0 : a0; m1 = ng1 ? -a1 : a1; m2 = ng2 ? -a2 : a2;
    case (deg)
      2'd0: push_root(0, 0, 0, 0, (m0 == 0) ? ST_OK : ST_NOROOT, 1);
      2'd1: begin
        if (m1 == 0) push_root(0, 0, 0, 0, ST_ZEROLEAD, 1);
        else push_root(ng0 == ng1, fx_quot(m0, m1), 0, 0, ST_OK, 1);
      end
      2'd3: push_root(0, 0, 0, 0, ST_UNSUP, 1);
      default: begin
        if (m2 == 0) begin
          push_root(0, 0, 0, 0, ST_ZEROLEAD, 1);
        end else begin
          den = m2 * 2;
          disc = a1 * a1 - 4 * a2 * a0;
          nbneg = a1 > 0;
          if (disc == 0) begin
            push_root(nbneg != ng2, fx_quot(m1, den), 0, 0, ST_OK, 1);
          end else begin
            s = floor_sqrt(disc < 0 ? -disc : disc);
            if (disc > 0) begin
              nb = -a1;
              n1 = nb + $signed(s);
              n2 = nb - $signed(s);
              push_root((n1 < 0) != ng2, fx_quot(n1 < 0 ? -n1 : n1, den), 0, 0, ST_OK, 0);
              push_root((n2 < 0) != ng2, fx_quot(n2 < 0 ? -n2 : n2, den), 0, 0, ST_OK, 1);
            end else begin
              push_root(nbneg != ng2, fx_quot(m1, den), ng2, fx_quot(s, den), ST_OK, 0);
              push_root(nbneg != ng2, fx_quot(m1, den), !ng2, fx_quot(s, den), ST_OK, 1);
            end
          end
        end
      end
    endcase
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // compare each result beat with the oldest expected root
  always @(posedge clk) begin
    root_t w;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (roots_due.size() == 0) begin
        report_mismatch("unexpected root beat, status", status, -1);
      end else begin
        w = roots_due.pop_front();
        if (root_real !== w.re) report_mismatch("root_real", root_real, w.re);
        if (root_imag !== w.im) report_mismatch("root_imag", root_imag, w.im);
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (last !== w.lst) report_mismatch("last", last, w.lst);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("low_degree_polynomial_roots_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // receiver: random back pressure plus a long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_poly(logic [1:0] deg, logic signed [31:0] c0, logic signed [31:0] c1,
                           logic signed [31:0] c2, bit typed, status_t st);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    degree = deg; coef_a0 = c0; coef_a1 = c1; coef_a2 = c2;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    n_items++;
    if (typed) push_root(0, 0, 0, 0, st, 1);
    else predict_roots(deg, c0, c1, c2);
    @(negedge clk);
  endtask

  function automatic void add_row(logic [1:0] deg, logic signed [31:0] c0,
                                  logic signed [31:0] c1, logic signed [31:0] c2,
                                  bit typed, status_t st);
    stim_row_t r;
    r.deg = deg; r.a0 = c0; r.a1 = c1; r.a2 = c2; r.typed = typed; r.st = st;
    dir_rows.push_back(r);
  endfunction

  function automatic logic signed [31:0] pick_coef();
    case ($urandom_range(5))
      0: return $urandom_range(1 << 20) - (1 << 19);
      1: begin
        case ($urandom_range(4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      2: return ($urandom_range(32) - 16) <<< FRAC;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [1:0] deg;
    logic signed [31:0] c0, c1, c2, m;
    int p;
    p = $urandom_range(99);
    deg = (p < 10) ? 2'd0 : (p < 30) ? 2'd1 : (p < 90) ? 2'd2 : 2'd3;
    c0 = pick_coef(); c1 = pick_coef(); c2 = pick_coef();
    // double root: a1 = +-2m with a2 = a0 = m
    if (deg == 2'd2 && $urandom_range(99) < 15) begin
      m = $urandom_range(1, 1 << 20);
      if ($urandom_range(1)) m = -m;
      c2 = m; c0 = m;
      c1 = $urandom_range(1) ? 2 * m : -2 * m;
    end
    send_poly(deg, c0, c1, c2, 0, ST_OK);
  endtask

  initial begin
    // rows typed in by hand first, then rows left to the predictor
    add_row(2'd0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 1, ST_OK);
    add_row(2'd0, 1, 0, 0, 1, ST_NOROOT);
    add_row(2'd0, 32'sh8000_0000, 0, 0, 1, ST_NOROOT);
    add_row(2'd0, 32'sh7fff_ffff, -1, -1, 1, ST_NOROOT);
    add_row(2'd1, 32'sh1234_5678, 0, 32'sh7fff_ffff, 1, ST_ZEROLEAD);
    add_row(2'd2, 32'sh7fff_ffff, 32'sh8000_0000, 0, 1, ST_ZEROLEAD);
    add_row(2'd3, 0, 0, 0, 1, ST_UNSUP);
    add_row(2'd3, -1, -1, -1, 1, ST_UNSUP);
    add_row(2'd1, 32'sh7fff_ffff, 1, 0, 0, ST_OK);
    add_row(2'd1, 32'sh8000_0000, -1, 0, 0, ST_OK);
    add_row(2'd1, 32'sh8000_0000, 32'sh8000_0000, -1, 0, ST_OK);
    add_row(2'd1, 3 << FRAC, -(2 << FRAC), 0, 0, ST_OK);
    add_row(2'd2, -(1 << FRAC), 0, 1 << FRAC, 0, ST_OK);
    add_row(2'd2, 1 << FRAC, 0, 1 << FRAC, 0, ST_OK);
    add_row(2'd2, 1 << FRAC, 2 << FRAC, 1 << FRAC, 0, ST_OK);
    add_row(2'd2, 6 << FRAC, -(5 << FRAC), 1 << FRAC, 0, ST_OK);
    add_row(2'd2, 5 << FRAC, 2 << FRAC, -(1 << FRAC), 0, ST_OK);
    add_row(2'd2, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, ST_OK);
    add_row(2'd2, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, ST_OK);
    add_row(2'd2, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 0, ST_OK);
    add_row(2'd2, 32'sh8000_0000, 0, 1, 0, ST_OK);
    add_row(2'd2, 1, 0, 32'sh7fff_ffff, 0, ST_OK);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table, no idling
    foreach (dir_rows[i])
      send_poly(dir_rows[i].deg, dir_rows[i].a0, dir_rows[i].a1, dir_rows[i].a2,
                dir_rows[i].typed, dir_rows[i].st);

    // sender pauses until everything has drained
    in_valid = 1'b0;
    wait (roots_due.size() == 0);
    repeat (160) @(negedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 57 : 0;
      rx_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 32 : 0;
      for (int k = 0; k < N_RANDOM / 3; k++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 2 && k == 40) hold_cnt = 400;
        send_random();
      end
    end
    in_valid = 1'b0;

    wait (roots_due.size() == 0);
    repeat (200) @(posedge clk);

    $display("covered %0d polynomials of degree 0..3 and %0d root beats,", n_items, n_results);
    $display("under three idling mixes with a long output hold-off and a drain pause");
    if (err_count == 0) begin
      $display("low_degree_polynomial_roots_unit_tb: done, clean");
    end else begin
      $display("low_degree_polynomial_roots_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/lpr_pkg.sv
design/lpr_front.sv
design/lpr_fifo.sv
design/lpr_back.sv
design/low_degree_polynomial_roots_unit.sv
tb/sv/low_degree_polynomial_roots_unit_tb.sv
